### hw/rtl/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg: shared types and constants of the FIR convolution stream
// Field widths, register indexes, item function codes and control structs.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int DEF_MAX_TAPS = 64;

    localparam int VALUE_W    = 16;
    localparam int IDX_W      = 6;
    localparam int SUM_W      = 38;
    localparam int PROD_W     = 32;
    localparam int TAPS_CFG_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0]  CFG_TAPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_SHAPE = 1'b1;
    localparam logic [TAPS_CFG_W-1:0] TAPS_RST  = 7'd64;

    localparam logic FUNC_COEF   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic clear;
    } t_ring_ctl;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } t_mac_ctl;

endpackage

### hw/rtl/fcs_if.sv
// ----------------------------------------------------------------------------
// fcs_in_if / fcs_out_if: stream channels of the FIR convolution stream
// Valid/ready channels carrying the input word and the result word.
// ----------------------------------------------------------------------------
interface fcs_in_if import fcs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [IDX_W-1:0]          coef_index;
    logic signed [VALUE_W-1:0] value;
    logic                      last_sample;

    modport source (output valid, func, coef_index, value, last_sample, input ready);
    modport sink   (input valid, func, coef_index, value, last_sample, output ready);
endinterface

interface fcs_out_if import fcs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum;
    logic                    last_out;

    modport source (output valid, sum, last_out, input ready);
    modport sink   (input valid, sum, last_out, output ready);
endinterface

### hw/rtl/fir_convolution_stream.sv
// After a sample word is taken, the ring walks past the MAC in RUN, then DRAIN and
// EMIT follow and the sum is registered at the output. A new sample word is taken
// only in IDLE, after one full turn of the tap ring past the single multiply-
// accumulate unit; tail outputs follow the last sample. Coefficient words are taken in IDLE.
// Reset (synchronous, active low) zeroes all coefficients and delayed samples
// and restores taps_in_use = 64, central_shape = 0.
// ----------------------------------------------------------------------------
// fir_convolution_stream: streaming FIR convolution with a loaded kernel
// A ring of tap cells rotates once per output past a shared MAC; full or
// central output shape, tail outputs and delay-line clear after the last word.
// ----------------------------------------------------------------------------
module fir_convolution_stream import fcs_pkg::*; #(
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fcs_in_if.sink                i_in_word,
    fcs_out_if.source             o_out_word
);

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int KW = $clog2(MAX_TAPS);
    localparam int CW = (TW > TAPS_CFG_W) ? TW : TAPS_CFG_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [TAPS_CFG_W-1:0]     r_cfg_taps;
    logic                      r_cfg_central;

    logic [1:0]                r_state;
    logic [KW-1:0]             r_k;
    logic [TW-1:0]             r_seen;
    logic [TW-1:0]             r_n;
    logic [TW-1:0]             r_t;
    logic [TW-1:0]             r_taps;
    logic [TW-1:0]             r_drop;
    logic [TW-1:0]             r_tail_end;
    logic                      r_central;
    logic                      r_last;

    logic                      r_out_valid;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_last_out;

    logic [TW-1:0]             w_taps;
    logic [TW-1:0]             w_drop;
    logic                      w_accept;
    logic                      w_take_sample;
    logic                      w_emit;
    logic                      w_go;
    logic                      w_more;
    logic signed [VALUE_W-1:0] w_shift_val;
    t_ring_ctl                 w_ring;
    t_mac_ctl                  w_mac;
    logic signed [SUM_W-1:0]   w_acc;

    logic signed [VALUE_W-1:0] w_coef   [MAX_TAPS];
    logic signed [VALUE_W-1:0] w_sample [MAX_TAPS];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_taps    <= TAPS_RST;
            r_cfg_central <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TAPS:  r_cfg_taps    <= i_cfg_data[TAPS_CFG_W-1:0];
                CFG_SHAPE: r_cfg_central <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // effective kernel length and dropped head outputs
    always_comb begin
        if (r_cfg_taps == '0) begin
            w_taps = TW'(1);
        end else if (CW'(r_cfg_taps) > CW'(MAX_TAPS)) begin
            w_taps = TW'(MAX_TAPS);
        end else begin
            w_taps = TW'(r_cfg_taps);
        end
        w_drop = r_cfg_central ? ((w_taps - TW'(1)) >> 1) : (w_taps - TW'(1));
    end

    assign w_accept      = i_in_word.valid && i_in_word.ready;
    assign w_take_sample = w_accept && (i_in_word.func == FUNC_SAMPLE);

    assign w_emit = !r_central || ((TW + 1)'(r_n) + (TW + 1)'(r_t) >= (TW + 1)'(r_drop));
    assign w_go   = (r_state == S_EMIT) && (!w_emit || !r_out_valid || o_out_word.ready);
    assign w_more = r_last && (r_t != r_tail_end);

    assign w_shift_val = (r_state == S_IDLE) ? i_in_word.value : '0;

    always_comb begin
        w_ring.shift  = w_take_sample || (w_go && w_more);
        w_ring.rotate = (r_state == S_RUN);
        w_ring.clear  = w_go && r_last && !w_more;
        w_mac.clear   = w_ring.shift;
        w_mac.mul_en  = (r_state == S_RUN) && (TW'(r_k) < r_taps);
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_seen  <= '0;
            r_t     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take_sample) begin
                        r_state <= S_RUN;
                        r_k     <= '0;
                        r_t     <= '0;
                        if (r_seen < TW'(MAX_TAPS)) begin
                            r_seen <= r_seen + TW'(1);
                        end
                    end
                end
                S_RUN: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(MAX_TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_go) begin
                        if (w_more) begin
                            r_state <= S_RUN;
                            r_k     <= '0;
                            r_t     <= r_t + TW'(1);
                        end else begin
                            r_state <= S_IDLE;
                            if (r_last) begin
                                r_seen <= '0;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // per-signal parameters, latched with the sample word
    always_ff @(posedge i_clk) begin
        if (w_take_sample) begin
            r_n        <= r_seen;
            r_taps     <= w_taps;
            r_drop     <= w_drop;
            r_tail_end <= r_cfg_central ? w_drop : (w_taps - TW'(1));
            r_central  <= r_cfg_central;
            r_last     <= i_in_word.last_sample;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_sum      <= w_acc;
            r_last_out <= r_last && (r_t == r_tail_end);
        end
    end

    assign i_in_word.ready   = (r_state == S_IDLE);
    assign o_out_word.valid  = r_out_valid;
    assign o_out_word.sum    = r_sum;
    assign o_out_word.last_out = r_last_out;

    // tap ring
    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
        localparam int NX = (i + 1) % MAX_TAPS;
        logic                      w_we;
        logic signed [VALUE_W-1:0] w_left;

        assign w_we = w_accept && (i_in_word.func == FUNC_COEF)
                      && (int'(i_in_word.coef_index) == i);

        if (i == 0) begin : g_head
            assign w_left = w_shift_val;
        end else begin : g_body
            assign w_left = w_sample[i-1];
        end

        fcs_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ring),
            .i_coef_we      (w_we),
            .i_coef_wdata   (i_in_word.value),
            .i_left_sample  (w_left),
            .i_right_coef   (w_coef[NX]),
            .i_right_sample (w_sample[NX]),
            .o_coef         (w_coef[i]),
            .o_sample       (w_sample[i])
        );
    end

    fcs_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac),
        .i_coef   (w_coef[0]),
        .i_sample (w_sample[0]),
        .o_acc    (w_acc)
    );

    a_run_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_k == KW'(MAX_TAPS - 1)) |=> (r_state == S_DRAIN))
        else $error("ring walk did not end after a full turn");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_t <= r_tail_end))
        else $error("tail step past its end");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring.clear |=> (r_seen == '0) && (r_state == S_IDLE))
        else $error("sample count not reset after last word");

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= TW'(MAX_TAPS))
        else $error("sample count over saturation");

endmodule

### hw/rtl/fcs_cell.sv
// ----------------------------------------------------------------------------
// fcs_cell: one tap cell of the coefficient/sample ring
// Holds one coefficient and one delayed sample. Samples shift toward the tail
// on a new input or a tail step; both values rotate toward the head in a walk.
// ----------------------------------------------------------------------------
module fcs_cell import fcs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ring_ctl                 i_ctl,
    input  logic                      i_coef_we,
    input  logic signed [VALUE_W-1:0] i_coef_wdata,
    input  logic signed [VALUE_W-1:0] i_left_sample,
    input  logic signed [VALUE_W-1:0] i_right_coef,
    input  logic signed [VALUE_W-1:0] i_right_sample,
    output logic signed [VALUE_W-1:0] o_coef,
    output logic signed [VALUE_W-1:0] o_sample
);

    logic signed [VALUE_W-1:0] r_coef;
    logic signed [VALUE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_coef_we) begin
            r_coef <= i_coef_wdata;
        end else if (i_ctl.rotate) begin
            r_coef <= i_right_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctl.clear) begin
            r_sample <= '0;
        end else if (i_ctl.shift) begin
            r_sample <= i_left_sample;
        end else if (i_ctl.rotate) begin
            r_sample <= i_right_sample;
        end
    end

    assign o_coef   = r_coef;
    assign o_sample = r_sample;

endmodule

### hw/rtl/fcs_mac.sv
// ----------------------------------------------------------------------------
// fcs_mac: multiply-accumulate at the head of the ring
// Registered 16x16 product, then a 38-bit wrapping accumulator.
// ----------------------------------------------------------------------------
module fcs_mac import fcs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctl                  i_ctl,
    input  logic signed [VALUE_W-1:0] i_coef,
    input  logic signed [VALUE_W-1:0] i_sample,
    output logic signed [SUM_W-1:0]   o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [SUM_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_coef) * PROD_W'(i_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_ctl.clear) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
